// ===== rtl/core/esrd_pkg.sv =====
package esrd_pkg;

    // voltage window for a usable run-detect sample
    localparam logic [15:0] VOLT_MIN_MV     = 16'd10000;
    localparam logic [15:0] VOLT_MAX_MV     = 16'd40000;
    // stick thresholds
    localparam logic [11:0] START_PULSE_US  = 12'd1600;
    localparam logic [11:0] ENGINE_PULSE_US = 12'd1100;
    localparam logic [7:0]  TRY_COUNT_MAX   = 8'd255;

    // configuration reset values
    localparam logic [15:0] RST_RUN_THRESHOLD_MV  = 16'd13500;
    localparam logic [15:0] RST_STOP_THRESHOLD_MV = 16'd12500;
    localparam logic [15:0] RST_CONFIRM_TIME_MS   = 16'd500;
    localparam logic [15:0] RST_CRANK_LIMIT_MS    = 16'd3000;
    localparam logic [15:0] RST_RESTART_GUARD_MS  = 16'd2000;
    localparam logic [15:0] RST_RETRY_GAP_MS      = 16'd1000;
    localparam logic [7:0]  RST_MAX_START_TRIES   = 8'd3;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int S_TDATA_W  = 80;
    localparam int M_TDATA_W  = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RUN_THRESHOLD  = 3'd0,
        CFG_STOP_THRESHOLD = 3'd1,
        CFG_CONFIRM_TIME   = 3'd2,
        CFG_CRANK_LIMIT    = 3'd3,
        CFG_RESTART_GUARD  = 3'd4,
        CFG_RETRY_GAP      = 3'd5,
        CFG_MAX_TRIES      = 3'd6
    } t_cfg_idx;

    typedef enum logic {
        OP_SAMPLE  = 1'b0,
        OP_STARTER = 1'b1
    } t_op;

    typedef struct packed {
        logic [15:0] run_threshold_mv;
        logic [15:0] stop_threshold_mv;
        logic [15:0] confirm_time_ms;
        logic [15:0] crank_limit_ms;
        logic [15:0] restart_guard_ms;
        logic [15:0] retry_gap_ms;
        logic [7:0]  max_start_tries;
    } t_cfg;

    typedef struct packed {
        logic        op;
        logic [31:0] now_ms;
        logic [15:0] voltage_mv;
        logic        voltage_valid;
        logic [11:0] starter_pulse_us;
        logic [11:0] engine_pulse_us;
        logic        throttle_neutral;
        logic        ignition_on;
        logic        system_fault;
        logic        drive_idle;
    } t_item;

    typedef struct packed {
        logic        running_flag;
        logic        starter_on;
        logic [31:0] run_confirm_since;
        logic [31:0] stop_confirm_since;
        logic [31:0] stopped_at;
        logic [31:0] crank_started_at;
        logic [31:0] last_try_at;
        logic [7:0]  try_count;
    } t_state;

    typedef struct packed {
        logic        engine_running;
        logic        starter_relay;
        logic        start_fault_request;
        logic [7:0]  failed_tries;
    } t_result;

endpackage

// ===== rtl/core/esrd_update.sv =====
module esrd_update (
    input  esrd_pkg::t_cfg    i_cfg,
    input  esrd_pkg::t_state  i_state,
    input  esrd_pkg::t_item   i_item,
    output esrd_pkg::t_state  o_state,
    output esrd_pkg::t_result o_result
);
    import esrd_pkg::*;

    logic [31:0] run_elapsed;
    logic [31:0] stop_elapsed;
    logic [31:0] since_stop;
    logic [31:0] crank_elapsed;
    logic [31:0] since_try;
    logic        volt_ok;
    logic        request;
    logic        blocked;
    logic [7:0]  tries_inc;
    logic        fault_req;
    t_state      nxt;

    // all differences wrap modulo 2^32
    assign run_elapsed   = i_item.now_ms - i_state.run_confirm_since;
    assign stop_elapsed  = i_item.now_ms - i_state.stop_confirm_since;
    assign since_stop    = i_item.now_ms - i_state.stopped_at;
    assign crank_elapsed = i_item.now_ms - i_state.crank_started_at;
    assign since_try     = i_item.now_ms - i_state.last_try_at;

    assign volt_ok = i_item.voltage_valid && (i_item.voltage_mv >= VOLT_MIN_MV)
                     && (i_item.voltage_mv <= VOLT_MAX_MV);
    assign request = i_item.starter_pulse_us > START_PULSE_US;
    assign blocked = i_item.system_fault || !i_item.drive_idle
                     || (i_item.engine_pulse_us > ENGINE_PULSE_US)
                     || !i_item.throttle_neutral || !i_item.ignition_on
                     || i_state.running_flag
                     || ((i_state.stopped_at != 32'd0)
                         && (since_stop < {16'd0, i_cfg.restart_guard_ms}));
    assign tries_inc = (i_state.try_count == TRY_COUNT_MAX) ? i_state.try_count
                       : i_state.try_count + 8'd1;

    always_comb begin
        nxt       = i_state;
        fault_req = 1'b0;
        if (i_item.op == OP_SAMPLE) begin
            if (i_state.starter_on) begin
                nxt.run_confirm_since  = 32'd0;
                nxt.stop_confirm_since = 32'd0;
            end else if (volt_ok) begin
                if (!i_state.running_flag) begin
                    nxt.stop_confirm_since = 32'd0;
                    if (i_item.voltage_mv >= i_cfg.run_threshold_mv) begin
                        if (i_state.run_confirm_since == 32'd0) begin
                            nxt.run_confirm_since = i_item.now_ms;
                        end else if (run_elapsed >= {16'd0, i_cfg.confirm_time_ms}) begin
                            nxt.running_flag      = 1'b1;
                            nxt.run_confirm_since = 32'd0;
                            nxt.try_count         = 8'd0;
                        end
                    end else begin
                        nxt.run_confirm_since = 32'd0;
                    end
                end else begin
                    nxt.run_confirm_since = 32'd0;
                    if (i_item.voltage_mv <= i_cfg.stop_threshold_mv) begin
                        if (i_state.stop_confirm_since == 32'd0) begin
                            nxt.stop_confirm_since = i_item.now_ms;
                        end else if (stop_elapsed >= {16'd0, i_cfg.confirm_time_ms}) begin
                            nxt.running_flag       = 1'b0;
                            nxt.stop_confirm_since = 32'd0;
                            nxt.stopped_at         = i_item.now_ms;
                        end
                    end else begin
                        nxt.stop_confirm_since = 32'd0;
                    end
                end
            end
        end else begin
            if (blocked) begin
                // interlock drops the starter without counting a failure
                nxt.starter_on = 1'b0;
            end else if (i_state.starter_on) begin
                if (!request || (crank_elapsed > {16'd0, i_cfg.crank_limit_ms})) begin
                    nxt.starter_on = 1'b0;
                    nxt.stopped_at = i_item.now_ms;
                    nxt.try_count  = tries_inc;
                    fault_req      = tries_inc >= i_cfg.max_start_tries;
                end
            end else if (request && (since_try >= {16'd0, i_cfg.retry_gap_ms})) begin
                nxt.last_try_at      = i_item.now_ms;
                nxt.starter_on       = 1'b1;
                nxt.crank_started_at = i_item.now_ms;
            end
        end
    end

    assign o_state                      = nxt;
    assign o_result.engine_running      = nxt.running_flag;
    assign o_result.starter_relay       = nxt.starter_on;
    assign o_result.start_fault_request = fault_req;
    assign o_result.failed_tries        = nxt.try_count;

endmodule

// ===== rtl/core/engine_start_and_run_detect.sv =====
// Engine start and run detection. Each input beat is one timestamped update:
// tuser 0 is a voltage run-detect sample, tuser 1 a starter update with its
// interlocks, retry gap, crank limit and restart guard. Every input beat
// yields exactly one output beat with the running flag, starter relay, a
// one-beat fault request and the saturating failed-start count. The block
// takes one beat per clock while the output is not stalled: the beat is held
// in an input register, the whole update is a single pass of compare and
// subtract logic into the state and the result register, and the next beat
// sees the state left by the one before. Configuration writes are registered
// and are meant to happen while no beat is in flight.
module engine_start_and_run_detect (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [esrd_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [esrd_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // now_ms[31:0], voltage_mv[47:32], voltage_valid[48], starter_pulse_us[60:49],
    // engine_pulse_us[72:61], throttle_neutral[73], ignition_on[74],
    // system_fault[75], drive_idle[76], zero[79:77]
    input  logic [esrd_pkg::S_TDATA_W-1:0]      s_axis_tdata,
    // op[0]
    input  logic                                s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // engine_running[0], starter_relay[1], start_fault_request[2],
    // failed_tries[10:3], zero[15:11]
    output logic [esrd_pkg::M_TDATA_W-1:0]      m_axis_tdata
);
    import esrd_pkg::*;

    t_cfg    r_cfg;
    t_state  r_state;
    t_state  n_state;
    t_item   r_in_item;
    t_item   in_item;
    logic    r_in_valid;
    t_result r_out;
    t_result n_out;
    logic    r_out_valid;
    logic    out_free;
    logic    advance;

    assign in_item.op               = s_axis_tuser;
    assign in_item.now_ms           = s_axis_tdata[31:0];
    assign in_item.voltage_mv       = s_axis_tdata[47:32];
    assign in_item.voltage_valid    = s_axis_tdata[48];
    assign in_item.starter_pulse_us = s_axis_tdata[60:49];
    assign in_item.engine_pulse_us  = s_axis_tdata[72:61];
    assign in_item.throttle_neutral = s_axis_tdata[73];
    assign in_item.ignition_on      = s_axis_tdata[74];
    assign in_item.system_fault     = s_axis_tdata[75];
    assign in_item.drive_idle       = s_axis_tdata[76];

    assign out_free      = !r_out_valid || m_axis_tready;
    assign advance       = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.run_threshold_mv  <= RST_RUN_THRESHOLD_MV;
            r_cfg.stop_threshold_mv <= RST_STOP_THRESHOLD_MV;
            r_cfg.confirm_time_ms   <= RST_CONFIRM_TIME_MS;
            r_cfg.crank_limit_ms    <= RST_CRANK_LIMIT_MS;
            r_cfg.restart_guard_ms  <= RST_RESTART_GUARD_MS;
            r_cfg.retry_gap_ms      <= RST_RETRY_GAP_MS;
            r_cfg.max_start_tries   <= RST_MAX_START_TRIES;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_RUN_THRESHOLD:  r_cfg.run_threshold_mv  <= i_cfg_data;
                CFG_STOP_THRESHOLD: r_cfg.stop_threshold_mv <= i_cfg_data;
                CFG_CONFIRM_TIME:   r_cfg.confirm_time_ms   <= i_cfg_data;
                CFG_CRANK_LIMIT:    r_cfg.crank_limit_ms    <= i_cfg_data;
                CFG_RESTART_GUARD:  r_cfg.restart_guard_ms  <= i_cfg_data;
                CFG_RETRY_GAP:      r_cfg.retry_gap_ms      <= i_cfg_data;
                CFG_MAX_TRIES:      r_cfg.max_start_tries   <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    esrd_update u_update (
        .i_cfg    (r_cfg),
        .i_state  (r_state),
        .i_item   (r_in_item),
        .o_state  (n_state),
        .o_result (n_out)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_item <= in_item;
        end
    end

    // state commits only when the beat moves into the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, r_out.failed_tries, r_out.start_fault_request,
                            r_out.starter_relay, r_out.engine_running};

endmodule
